// ===== src/assert_macros.svh =====
// Assertion macros shared by the tag lexer RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XTL_ASSERT_IMPL(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define XTL_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== src/xtl_pkg.sv =====
// Types and character constants for the XML tag line lexer.
// No dependencies; used by xtl_step, xml_tag_line_lexer_core and the testbench.
`default_nettype none

package xtl_pkg;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_OPEN    = 4'd1,
        ST_SLASH1  = 4'd2,
        ST_NAME    = 4'd3,
        ST_GAP     = 4'd4,
        ST_ATTNAME = 4'd5,
        ST_EQ      = 4'd6,
        ST_VALUE   = 4'd7,
        ST_SLASH2  = 4'd8,
        ST_DONE    = 4'd9,
        ST_REJECT  = 4'd10
    } lex_state_t;

    typedef enum logic [2:0] {
        ROLE_SKIP = 3'd0,
        ROLE_NAME = 3'd1,
        ROLE_ATTN = 3'd2,
        ROLE_ATTV = 3'd3,
        ROLE_ATTC = 3'd4,
        ROLE_REJ  = 3'd5
    } role_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_END   = 2'd1,
        KIND_SELF  = 2'd2
    } kind_t;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;

    typedef struct packed {
        lex_state_t  st;
        logic [7:0]  quote;
        kind_t       kind;
    } lex_ctx_t;

    typedef struct packed {
        role_t       role;
        logic [7:0]  echo;
        logic        line_done;
        logic        tag_ok;
        kind_t       tag_kind;
    } lex_res_t;

    localparam lex_ctx_t CTX_RESET = '{st: ST_IDLE, quote: 8'h00, kind: KIND_START};

endpackage

`default_nettype wire

// ===== src/xml_tag_line_lexer_core.sv =====
// Top level of the XML tag line lexer: input register, step logic, result register.
// Depends on xtl_pkg, xtl_step and assert_macros.svh.
`default_nettype none

// Lexes one line holding a single XML tag, one character word per cycle unless
// the result side stalls on m_ready. Every accepted word yields exactly one result
// word; an end-of-line word reports tag_ok and tag_kind and clears the lexer
// context. An accepted word is held in the input register; once the result
// register is free or m_ready is high, the step logic's result is loaded into the
// result register, m_valid rises and the context is updated. The input register
// also lets one more word in while a result is stalled on m_ready.
module xml_tag_line_lexer_core (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire        s_action,
    input  wire  [7:0] s_data_char,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [2:0] m_char_role,
    output logic [7:0] m_echo_char,
    output logic       m_line_done,
    output logic       m_tag_ok,
    output logic [1:0] m_tag_kind
);

`include "assert_macros.svh"

    logic              in_valid_reg;
    logic              in_action_reg;
    logic [7:0]        in_char_reg;
    logic              out_valid_reg;
    xtl_pkg::lex_res_t out_res_reg;
    xtl_pkg::lex_ctx_t ctx_reg;
    xtl_pkg::lex_ctx_t ctx_next;
    xtl_pkg::lex_res_t res_next;
    logic              advance;

    // word moves from input register to result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    xtl_step u_step (
        .action    (in_action_reg),
        .data_char (in_char_reg),
        .ctx       (ctx_reg),
        .ctx_next  (ctx_next),
        .res       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg       <= xtl_pkg::CTX_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                ctx_reg       <= ctx_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_char_reg   <= s_data_char;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_char_role = out_res_reg.role;
    assign m_echo_char = out_res_reg.echo;
    assign m_line_done = out_res_reg.line_done;
    assign m_tag_ok    = out_res_reg.tag_ok;
    assign m_tag_kind  = out_res_reg.tag_kind;

    // end-of-line word always leaves the context at reset
    `XTL_ASSERT_NEXT(a_eol_clears, aclk, aresetn, advance && in_action_reg,
        ctx_reg == xtl_pkg::CTX_RESET)
    // result register and context stay in step: a reject result means rejected
    `XTL_ASSERT_IMPL(a_rej_ctx, aclk, aresetn,
        out_valid_reg && (out_res_reg.role == xtl_pkg::ROLE_REJ),
        ctx_reg.st == xtl_pkg::ST_REJECT)
    // closing quote returns to the attribute gap
    `XTL_ASSERT_IMPL(a_attc_ctx, aclk, aresetn,
        out_valid_reg && (out_res_reg.role == xtl_pkg::ROLE_ATTC),
        ctx_reg.st == xtl_pkg::ST_GAP)
    // line summary carries no character and no kind without a good tag
    `XTL_ASSERT_IMPL(a_eol_fields, aclk, aresetn, out_valid_reg && out_res_reg.line_done,
        (out_res_reg.role == xtl_pkg::ROLE_SKIP) && (out_res_reg.echo == 8'h00) &&
        (out_res_reg.tag_ok || (out_res_reg.tag_kind == xtl_pkg::KIND_START)))

endmodule

`default_nettype wire

// ===== src/xtl_step.sv =====
// Combinational lexer step: classifies one word against the current context.
// Depends on xtl_pkg.
`default_nettype none

module xtl_step (
    input  wire              action,
    input  wire  [7:0]       data_char,
    input  xtl_pkg::lex_ctx_t ctx,
    output xtl_pkg::lex_ctx_t ctx_next,
    output xtl_pkg::lex_res_t res
);

    logic is_space;
    logic is_slash;
    logic is_gt;

    assign is_space = (data_char == xtl_pkg::CH_SPACE);
    assign is_slash = (data_char == xtl_pkg::CH_SLASH);
    assign is_gt    = (data_char == xtl_pkg::CH_GT);

    always_comb begin
        ctx_next      = ctx;
        res.role      = xtl_pkg::ROLE_SKIP;
        res.echo      = data_char;
        res.line_done = 1'b0;
        res.tag_ok    = 1'b0;
        res.tag_kind  = xtl_pkg::KIND_START;

        if (action) begin
            // end of line: report and return to reset context
            res.echo      = 8'h00;
            res.line_done = 1'b1;
            res.tag_ok    = (ctx.st == xtl_pkg::ST_DONE);
            res.tag_kind  = (ctx.st == xtl_pkg::ST_DONE) ? ctx.kind : xtl_pkg::KIND_START;
            ctx_next      = xtl_pkg::CTX_RESET;
        end else begin
            case (ctx.st)
                xtl_pkg::ST_IDLE: begin
                    if (data_char == xtl_pkg::CH_LT) begin
                        ctx_next.st = xtl_pkg::ST_OPEN;
                    end else if (!is_space) begin
                        ctx_next.st = xtl_pkg::ST_REJECT;
                        res.role    = xtl_pkg::ROLE_REJ;
                    end
                end
                xtl_pkg::ST_OPEN: begin
                    if (is_slash) begin
                        ctx_next.kind = xtl_pkg::KIND_END;
                        ctx_next.st   = xtl_pkg::ST_SLASH1;
                    end else if (!is_space) begin
                        ctx_next.st = xtl_pkg::ST_NAME;
                        res.role    = xtl_pkg::ROLE_NAME;
                    end
                end
                xtl_pkg::ST_SLASH1: begin
                    if (!is_space) begin
                        ctx_next.st = xtl_pkg::ST_NAME;
                        res.role    = xtl_pkg::ROLE_NAME;
                    end
                end
                xtl_pkg::ST_NAME: begin
                    if (is_space) begin
                        ctx_next.st = xtl_pkg::ST_GAP;
                    end else if (is_slash) begin
                        ctx_next.kind = xtl_pkg::KIND_SELF;
                        ctx_next.st   = xtl_pkg::ST_SLASH2;
                    end else if (is_gt) begin
                        ctx_next.st = xtl_pkg::ST_DONE;
                    end else begin
                        res.role = xtl_pkg::ROLE_NAME;
                    end
                end
                xtl_pkg::ST_GAP: begin
                    if (is_slash) begin
                        ctx_next.kind = xtl_pkg::KIND_SELF;
                        ctx_next.st   = xtl_pkg::ST_SLASH2;
                    end else if (is_gt) begin
                        ctx_next.st = xtl_pkg::ST_DONE;
                    end else if (!is_space) begin
                        ctx_next.st = xtl_pkg::ST_ATTNAME;
                        res.role    = xtl_pkg::ROLE_ATTN;
                    end
                end
                xtl_pkg::ST_ATTNAME: begin
                    if (data_char == xtl_pkg::CH_EQ) begin
                        ctx_next.st = xtl_pkg::ST_EQ;
                    end else begin
                        res.role = xtl_pkg::ROLE_ATTN;
                    end
                end
                xtl_pkg::ST_EQ: begin
                    // anything but a quote is skipped here
                    if (data_char == xtl_pkg::CH_DQ || data_char == xtl_pkg::CH_SQ) begin
                        ctx_next.quote = data_char;
                        ctx_next.st    = xtl_pkg::ST_VALUE;
                    end
                end
                xtl_pkg::ST_VALUE: begin
                    if (data_char == ctx.quote) begin
                        ctx_next.st = xtl_pkg::ST_GAP;
                        res.role    = xtl_pkg::ROLE_ATTC;
                    end else begin
                        res.role = xtl_pkg::ROLE_ATTV;
                    end
                end
                xtl_pkg::ST_SLASH2: begin
                    if (is_gt) begin
                        ctx_next.st = xtl_pkg::ST_DONE;
                    end
                end
                xtl_pkg::ST_DONE: begin
                    // trailing text is skipped, line stays accepted
                end
                default: begin
                    ctx_next.st = xtl_pkg::ST_REJECT;
                    res.role    = xtl_pkg::ROLE_REJ;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_xml_tag_line_lexer_core.sv =====
// Self-checking testbench for xml_tag_line_lexer_core: directed tag lines, then random lines.
// Depends on xtl_pkg for the state, role and kind codes and the character constants.
`default_nettype none

// Tracks the lexer context, predicts the label of every accepted word
// and checks the labels that come out of the block in order.
class tag_lex_tracker;
    xtl_pkg::lex_state_t st;
    logic [7:0]          quote;
    xtl_pkg::kind_t      kind;
    xtl_pkg::lex_res_t   labels[$];
    int                  mismatches;
    int                  checked;
    int                  tags_start;
    int                  tags_end;
    int                  tags_self;
    int                  lines_failed;

    function new();
        st           = xtl_pkg::ST_IDLE;
        quote        = 8'h00;
        kind         = xtl_pkg::KIND_START;
        mismatches   = 0;
        checked      = 0;
        tags_start   = 0;
        tags_end     = 0;
        tags_self    = 0;
        lines_failed = 0;
    endfunction

    function int pending();
        return labels.size();
    endfunction

    function void note_word(bit is_eol, logic [7:0] ch);
        xtl_pkg::lex_res_t r;
        r = '{role: xtl_pkg::ROLE_SKIP, echo: ch, line_done: 1'b0, tag_ok: 1'b0,
              tag_kind: xtl_pkg::KIND_START};
        if (is_eol) begin
            r.echo      = 8'h00;
            r.line_done = 1'b1;
            r.tag_ok    = (st == xtl_pkg::ST_DONE);
            r.tag_kind  = r.tag_ok ? kind : xtl_pkg::KIND_START;
            st    = xtl_pkg::ST_IDLE;
            quote = 8'h00;
            kind  = xtl_pkg::KIND_START;
        end else begin
            case (st)
                xtl_pkg::ST_IDLE: begin
                    if (ch == xtl_pkg::CH_LT) begin
                        st = xtl_pkg::ST_OPEN;
                    end else if (ch != xtl_pkg::CH_SPACE) begin
                        st     = xtl_pkg::ST_REJECT;
                        r.role = xtl_pkg::ROLE_REJ;
                    end
                end
                xtl_pkg::ST_OPEN: begin
                    if (ch == xtl_pkg::CH_SLASH) begin
                        kind = xtl_pkg::KIND_END;
                        st   = xtl_pkg::ST_SLASH1;
                    end else if (ch != xtl_pkg::CH_SPACE) begin
                        st     = xtl_pkg::ST_NAME;
                        r.role = xtl_pkg::ROLE_NAME;
                    end
                end
                xtl_pkg::ST_SLASH1: begin
                    if (ch != xtl_pkg::CH_SPACE) begin
                        st     = xtl_pkg::ST_NAME;
                        r.role = xtl_pkg::ROLE_NAME;
                    end
                end
                xtl_pkg::ST_NAME: begin
                    if (ch == xtl_pkg::CH_SPACE) begin
                        st = xtl_pkg::ST_GAP;
                    end else if (ch == xtl_pkg::CH_SLASH) begin
                        kind = xtl_pkg::KIND_SELF;
                        st   = xtl_pkg::ST_SLASH2;
                    end else if (ch == xtl_pkg::CH_GT) begin
                        st = xtl_pkg::ST_DONE;
                    end else begin
                        r.role = xtl_pkg::ROLE_NAME;
                    end
                end
                xtl_pkg::ST_GAP: begin
                    if (ch == xtl_pkg::CH_SLASH) begin
                        kind = xtl_pkg::KIND_SELF;
                        st   = xtl_pkg::ST_SLASH2;
                    end else if (ch == xtl_pkg::CH_GT) begin
                        st = xtl_pkg::ST_DONE;
                    end else if (ch != xtl_pkg::CH_SPACE) begin
                        st     = xtl_pkg::ST_ATTNAME;
                        r.role = xtl_pkg::ROLE_ATTN;
                    end
                end
                xtl_pkg::ST_ATTNAME: begin
                    if (ch == xtl_pkg::CH_EQ) st = xtl_pkg::ST_EQ;
                    else r.role = xtl_pkg::ROLE_ATTN;
                end
                xtl_pkg::ST_EQ: begin
                    // anything but a quote is junk and skipped
                    if (ch == xtl_pkg::CH_DQ || ch == xtl_pkg::CH_SQ) begin
                        quote = ch;
                        st    = xtl_pkg::ST_VALUE;
                    end
                end
                xtl_pkg::ST_VALUE: begin
                    if (ch == quote) begin
                        st     = xtl_pkg::ST_GAP;
                        r.role = xtl_pkg::ROLE_ATTC;
                    end else begin
                        r.role = xtl_pkg::ROLE_ATTV;
                    end
                end
                xtl_pkg::ST_SLASH2: begin
                    if (ch == xtl_pkg::CH_GT) st = xtl_pkg::ST_DONE;
                end
                xtl_pkg::ST_DONE: begin
                end
                default: begin
                    st     = xtl_pkg::ST_REJECT;
                    r.role = xtl_pkg::ROLE_REJ;
                end
            endcase
        end
        labels = {labels, r};
    endfunction

    function void check_word(logic [2:0] role, logic [7:0] echo, logic done,
                             logic ok, logic [1:0] kind_out);
        xtl_pkg::lex_res_t e;
        checked++;
        if (labels.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result word %0d: role=%0d echo=%02h done=%b ok=%b kind=%0d",
                         checked, role, echo, done, ok, kind_out);
            mismatches++;
            return;
        end
        e = labels.pop_front();
        if (e.line_done) begin
            if (!e.tag_ok) lines_failed++;
            else if (e.tag_kind == xtl_pkg::KIND_START) tags_start++;
            else if (e.tag_kind == xtl_pkg::KIND_END) tags_end++;
            else tags_self++;
        end
        if (role !== e.role || echo !== e.echo || done !== e.line_done ||
            ok !== e.tag_ok || kind_out !== e.tag_kind) begin
            if (mismatches < 10) begin
                $display("mismatch on result word %0d", checked);
                $display("  expected role=%0d echo=%02h done=%b ok=%b kind=%0d",
                         e.role, e.echo, e.line_done, e.tag_ok, e.tag_kind);
                $display("  actual   role=%0d echo=%02h done=%b ok=%b kind=%0d",
                         role, echo, done, ok, kind_out);
            end
            mismatches++;
        end
    endfunction
endclass

module tb_xml_tag_line_lexer_core;

    localparam int RANDOM_WORDS = 800;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 200000;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_action    = 1'b0;
    logic [7:0] s_data_char = 8'h00;
    logic       m_ready     = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire  [2:0] m_char_role;
    wire  [7:0] m_echo_char;
    wire        m_line_done;
    wire        m_tag_ok;
    wire  [1:0] m_tag_kind;

    tag_lex_tracker sb = new();

    logic [7:0] line_buf[$];
    int  words_sent  = 0;
    int  lines_sent  = 0;
    int  burst_left  = 0;
    int  steady_left = 0;
    bit  hold_req    = 1'b0;

    xml_tag_line_lexer_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data_char (s_data_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_role (m_char_role),
        .m_echo_char (m_echo_char),
        .m_line_done (m_line_done),
        .m_tag_ok    (m_tag_ok),
        .m_tag_kind  (m_tag_kind)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("xml_tag_line_lexer_core regression: fail");
        $finish;
    end

    // Result side: check every accepted word, then pick the next ready value.
    initial begin
        rx_mode_t mode;
        int mode_left;
        int hold_left;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_word(m_char_role, m_echo_char, m_line_done, m_tag_ok, m_tag_kind);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // Leaves valid high after the handshake while a burst or steady run remains; else drops it for a gap.
    task automatic send_word(input bit is_eol, input logic [7:0] ch);
        int gap;
        s_valid     <= 1'b1;
        s_action    <= is_eol;
        s_data_char <= ch;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(is_eol, ch);
        words_sent++;
        if (steady_left > 0) begin
            steady_left--;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left  = $urandom_range(0, 30);
            gap         = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                      : $urandom_range(1, 3);
            s_valid     <= 1'b0;
            s_data_char <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic void put_byte(input logic [7:0] b);
        line_buf = {line_buf, b};
    endfunction

    task automatic send_line();
        foreach (line_buf[i]) send_word(1'b0, line_buf[i]);
        send_word(1'b1, 8'($urandom_range(0, 255)));
        lines_sent++;
    endtask

    task automatic send_text(input string txt);
        line_buf.delete();
        for (int i = 0; i < txt.len(); i++) put_byte(txt[i]);
        send_line();
    endtask

    // Biased toward the bytes the lexer reacts to.
    function automatic logic [7:0] any_byte();
        logic [7:0] marks[9];
        marks = '{xtl_pkg::CH_LT, xtl_pkg::CH_SLASH, xtl_pkg::CH_GT, xtl_pkg::CH_EQ,
                  xtl_pkg::CH_SPACE, xtl_pkg::CH_DQ, xtl_pkg::CH_SQ, 8'h00, 8'hFF};
        if ($urandom_range(0, 1) == 0) return marks[$urandom_range(0, 8)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do b = any_byte();
        while (b == xtl_pkg::CH_SPACE || b == xtl_pkg::CH_SLASH || b == xtl_pkg::CH_GT);
        return b;
    endfunction

    function automatic logic [7:0] attr_byte();
        logic [7:0] b;
        do b = any_byte();
        while (b == xtl_pkg::CH_SPACE || b == xtl_pkg::CH_SLASH || b == xtl_pkg::CH_GT ||
               b == xtl_pkg::CH_EQ);
        return b;
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] q1, input logic [7:0] q2);
        logic [7:0] b;
        do b = any_byte(); while (b == q1 || b == q2);
        return b;
    endfunction

    // Mostly well-formed tags with random content; some noise, some cut or corrupted.
    task automatic compose_line();
        int         shape;
        int         attrs;
        int         cut;
        logic [7:0] q;
        line_buf.delete();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) put_byte(any_byte());
        end else begin
            repeat ($urandom_range(0, 2)) put_byte(xtl_pkg::CH_SPACE);
            put_byte(xtl_pkg::CH_LT);
            shape = $urandom_range(0, 2);
            if (shape == xtl_pkg::KIND_END) begin
                put_byte(xtl_pkg::CH_SLASH);
                if ($urandom_range(0, 3) == 0) put_byte(xtl_pkg::CH_SPACE);
            end
            repeat ($urandom_range(1, 4)) put_byte(name_byte());
            attrs = (shape == xtl_pkg::KIND_END) ? 0 : $urandom_range(0, 2);
            repeat (attrs) begin
                repeat ($urandom_range(1, 2)) put_byte(xtl_pkg::CH_SPACE);
                repeat ($urandom_range(1, 3)) put_byte(attr_byte());
                put_byte(xtl_pkg::CH_EQ);
                if ($urandom_range(0, 3) == 0)
                    put_byte(other_than(xtl_pkg::CH_DQ, xtl_pkg::CH_SQ));
                q = $urandom_range(0, 1) ? xtl_pkg::CH_DQ : xtl_pkg::CH_SQ;
                put_byte(q);
                repeat ($urandom_range(0, 3)) put_byte(other_than(q, q));
                put_byte(q);
            end
            if ($urandom_range(0, 2) == 0) put_byte(xtl_pkg::CH_SPACE);
            if (shape == xtl_pkg::KIND_SELF) put_byte(xtl_pkg::CH_SLASH);
            put_byte(xtl_pkg::CH_GT);
            repeat ($urandom_range(0, 2)) put_byte(any_byte());
            if ($urandom_range(0, 7) == 0) begin
                cut = $urandom_range(0, line_buf.size() - 1);
                while (line_buf.size() > cut) void'(line_buf.pop_back());
            end else if ($urandom_range(0, 7) == 0) begin
                line_buf[$urandom_range(0, line_buf.size() - 1)] = any_byte();
            end
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int  first_random;
        bit  hold_done;
        bit  drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // leading space and a slash right after the name
        send_text(" <a/>");
        send_text("</b>");
        // junk after '=', a single quote inside a double-quoted value, text after '>'
        send_text("<e k=x\"'\">z");
        // stray byte at the start of the line rejects the rest of the line
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b1, 8'hFF);
        lines_sent++;

        first_random = words_sent;
        while (words_sent - first_random < RANDOM_WORDS) begin
            if (!hold_done && words_sent - first_random > 250) begin
                // keep offering words while the result side is held off
                hold_done   = 1'b1;
                hold_req    = 1'b1;
                steady_left = 120;
            end
            if (!drain_done && words_sent - first_random > 550) begin
                drain_done = 1'b1;
                drain();
                @(posedge aclk);
            end
            compose_line();
            send_line();
        end

        drain();
        repeat (8) @(posedge aclk);

        $display("sent %0d words in %0d lines, %0d result words checked",
                 words_sent, lines_sent, sb.checked);
        $display("accepted tags: %0d start, %0d end, %0d self-closing; %0d lines not accepted",
                 sb.tags_start, sb.tags_end, sb.tags_self, sb.lines_failed);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("xml_tag_line_lexer_core regression: pass");
        end else begin
            $display("xml_tag_line_lexer_core regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/xtl_pkg.sv
src/xtl_step.sv
src/xml_tag_line_lexer_core.sv
tb/tb_xml_tag_line_lexer_core.sv
